### rtl/core/crbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crbp_pkg;

    localparam int FPP_DEFAULT     = 384;
    localparam int SEQ_MOD_DEFAULT = 252;

    localparam int SAMPLE_W  = 16;
    localparam int NUM_CH    = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int BYTE_W    = 8;
    localparam int SEQ_OUT_W = 8;
    localparam int SLOT_OUT_W = 9;
    localparam int OUT_PAD_W = OUT_TDATA_W - NUM_CH * BYTE_W - SEQ_OUT_W - SLOT_OUT_W;

    localparam int STEP_W    = 19;
    localparam int PHASE_W   = 20;
    localparam int VW        = 18;
    localparam int XW        = 41;
    localparam int MUL_LO_W  = 24;
    localparam int MUL_A_W   = MUL_LO_W + 1;
    localparam int PRODW     = MUL_A_W + VW;
    localparam int ACCW      = 60;

    localparam logic [PHASE_W-1:0] ONE_Q16    = PHASE_W'(65536);
    localparam logic [STEP_W-1:0]  MIN_STEP   = STEP_W'(16384);
    localparam logic [STEP_W-1:0]  RATE_RESET = STEP_W'(120422);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MLO,
        OP_MHI,
        OP_MACC,
        OP_UPD,
        OP_BYTE
    } lane_op_t;

    typedef enum logic [1:0] {
        TERM_A,
        TERM_B,
        TERM_C
    } term_t;

    typedef struct packed {
        logic     accept;
        lane_op_t op;
        term_t    term;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_lt_one;
        logic more;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/crbp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module crbp_lane
    import crbp_pkg::*;
(
    input  wire logic                       aclk,
    input  wire lane_op_t                   op,
    input  wire term_t                      term,
    input  wire logic signed [SAMPLE_W-1:0] m3,
    input  wire logic signed [SAMPLE_W-1:0] m1,
    input  wire logic signed [SAMPLE_W-1:0] p1,
    input  wire logic signed [SAMPLE_W-1:0] p3,
    input  wire logic signed [VW-1:0]       vec,
    output logic [BYTE_W-1:0]               byte_out
);

    localparam int DW  = XW + 1;
    localparam int D85W = DW + 7;
    localparam int QW  = D85W - 36;
    localparam logic signed [DW-1:0] D_OFFSET = DW'(3) << 35;

    logic signed [XW-1:0]      g1, g3, h1, h3;
    logic signed [XW-1:0]      ta, tb, tc;
    logic signed [XW-1:0]      a0_calc, b0_calc, c0_calc, xa_calc;
    logic signed [XW-1:0]      a0_reg, b0_reg, c0_reg, x_reg, x_upd;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [PRODW-1:0]   mul_p, prod_reg;
    logic signed [ACCW-1:0]    prod_ext, acc_reg, acc_sh;
    logic signed [DW-1:0]      d;
    logic signed [D85W-1:0]    d_ext, d85;
    logic [QW-1:0]             q;
    logic [BYTE_W-1:0]         byte_calc, byte_reg;

    always_comb begin
        g1 = XW'(p1) + XW'(m1);
        g3 = XW'(p3) + XW'(m3);
        h1 = XW'(p1) - XW'(m1);
        h3 = XW'(p3) - XW'(m3);
        ta = g3 - g1;
        a0_calc = ((ta <<< 1) + ta) <<< 16;
        tb = (h1 <<< 4) + (h1 <<< 3) + (h1 <<< 1) + h1 - h3;
        b0_calc = tb <<< 16;
        tc = (g1 <<< 4) + (g1 <<< 3) + (g1 <<< 1) + g1 - ((g3 <<< 1) + g3);
        c0_calc = tc <<< 16;
        xa_calc = h3 - ((h1 <<< 1) + h1);
    end

    always_comb begin
        if (op == OP_MHI) begin
            mul_a = {{(MUL_A_W-(XW-MUL_LO_W)){x_reg[XW-1]}}, x_reg[XW-1:MUL_LO_W]};
        end else begin
            mul_a = {1'b0, x_reg[MUL_LO_W-1:0]};
        end
        mul_p = mul_a * vec;
    end

    assign prod_ext = {{(ACCW-PRODW){prod_reg[PRODW-1]}}, prod_reg};
    assign acc_sh   = acc_reg >>> 16;

    always_comb begin
        case (term)
            TERM_A:  x_upd = a0_reg + $signed(acc_reg[XW-1:0]);
            TERM_B:  x_upd = b0_reg + $signed(acc_sh[XW-1:0]);
            TERM_C:  x_upd = c0_reg + $signed(acc_sh[XW-1:0]);
            default: x_upd = x_reg;
        endcase
    end

    always_comb begin
        d     = DW'(x_reg) + D_OFFSET;
        d_ext = D85W'(d);
        d85   = (d_ext <<< 6) + (d_ext <<< 4) + (d_ext <<< 2) + d_ext;
        q     = d85[D85W-1:36];
        if (d <= 0) begin
            byte_calc = '0;
        end else if (q > QW'(255)) begin
            byte_calc = '1;
        end else begin
            byte_calc = q[BYTE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                a0_reg <= a0_calc;
                b0_reg <= b0_calc;
                c0_reg <= c0_calc;
                x_reg  <= xa_calc;
            end
            OP_MLO: begin
                prod_reg <= mul_p;
            end
            OP_MHI: begin
                prod_reg <= mul_p;
                acc_reg  <= prod_ext;
            end
            OP_MACC: begin
                acc_reg <= acc_reg + (prod_ext <<< MUL_LO_W);
            end
            OP_UPD: begin
                x_reg <= x_upd;
            end
            OP_BYTE: begin
                byte_reg <= byte_calc;
            end
            default: begin
            end
        endcase
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

### rtl/core/crbp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module crbp_datapath
    import crbp_pkg::*;
#(
    parameter int FRAMES_PER_PACKET = FPP_DEFAULT,
    parameter int SEQ_MODULUS       = SEQ_MOD_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  status,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic [STEP_W-1:0]      cfg_data,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast
);

    localparam int SLOT_W = (FRAMES_PER_PACKET > 1) ? $clog2(FRAMES_PER_PACKET) : 1;
    localparam int SEQ_W  = $clog2(SEQ_MODULUS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAMES_PER_PACKET - 1);
    localparam logic [SEQ_W-1:0]  SEQ_LAST  = SEQ_W'(SEQ_MODULUS - 1);

    logic signed [SAMPLE_W-1:0] hist_reg [4][NUM_CH];
    logic [PHASE_W-1:0]         phase_reg;
    logic [STEP_W-1:0]          rate_step_reg, step;
    logic [PHASE_W:0]           phase_sum;
    logic signed [VW-1:0]       vec;
    logic [SLOT_W-1:0]          slot_count_reg;
    logic [SEQ_W-1:0]           packet_count_reg;
    logic [BYTE_W-1:0]          lane_byte [NUM_CH];
    logic [BYTE_W-1:0]          out_byte_reg [NUM_CH];
    logic [SEQ_OUT_W-1:0]       out_seq_reg;
    logic [SLOT_OUT_W-1:0]      out_slot_reg;
    logic                       out_last_reg;
    logic                       m_tvalid_reg;
    logic                       phase_lt_one;

    assign step         = (rate_step_reg < MIN_STEP) ? MIN_STEP : rate_step_reg;
    assign phase_sum    = {1'b0, phase_reg} + (PHASE_W + 1)'(step);
    assign phase_lt_one = phase_reg < ONE_Q16;
    assign vec          = {~phase_reg[15], ~phase_reg[15], phase_reg[14:0], 1'b0};

    assign status.phase_lt_one = phase_lt_one;
    assign status.more         = phase_sum < (PHASE_W + 1)'(ONE_Q16);
    assign status.out_free     = !m_tvalid_reg || m_tready;

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        crbp_lane u_lane (
            .aclk     (aclk),
            .op       (cmd.op),
            .term     (cmd.term),
            .m3       (hist_reg[3][ch]),
            .m1       (hist_reg[2][ch]),
            .p1       (hist_reg[1][ch]),
            .p3       (hist_reg[0][ch]),
            .vec      (vec),
            .byte_out (lane_byte[ch])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    hist_reg[i][ch] <= '0;
                end
            end
            phase_reg        <= ONE_Q16;
            rate_step_reg    <= RATE_RESET;
            slot_count_reg   <= '0;
            packet_count_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                rate_step_reg <= cfg_data;
            end
            if (cmd.accept) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    hist_reg[0][ch] <= $signed(s_tdata[ch*SAMPLE_W +: SAMPLE_W]);
                end
                for (int i = 1; i < 4; i++) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                phase_reg <= (phase_reg >= ONE_Q16) ? phase_reg - ONE_Q16 : '0;
            end
            if (cmd.emit) begin
                phase_reg    <= phase_sum[PHASE_W-1:0];
                m_tvalid_reg <= 1'b1;
                if (slot_count_reg == SLOT_LAST) begin
                    slot_count_reg   <= '0;
                    packet_count_reg <= (packet_count_reg == SEQ_LAST) ? '0
                                        : packet_count_reg + 1'b1;
                end else begin
                    slot_count_reg <= slot_count_reg + 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_byte_reg <= lane_byte;
            out_seq_reg  <= SEQ_OUT_W'(packet_count_reg);
            out_slot_reg <= SLOT_OUT_W'(slot_count_reg);
            out_last_reg <= !status.more;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_slot_reg, out_seq_reg,
                       out_byte_reg[2], out_byte_reg[1], out_byte_reg[0]};

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("result issued while output register busy");

    a_accept_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> (!cmd.emit && cmd.op == OP_NONE))
        else $error("request taken during evaluation");

    a_op_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op != OP_NONE) |-> phase_lt_one)
        else $error("evaluation with phase at or above one");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid_reg)
        else $error("issued result not presented");

endmodule

`default_nettype wire

### rtl/core/crbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module crbp_ctrl
    import crbp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CHECK = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_MLO   = 9'b000001000,
        ST_MHI   = 9'b000010000,
        ST_MACC  = 9'b000100000,
        ST_UPD   = 9'b001000000,
        ST_BYTE  = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    term_t  term_reg, term_next, term_succ;

    always_comb begin
        case (term_reg)
            TERM_A:  term_succ = TERM_B;
            TERM_B:  term_succ = TERM_C;
            default: term_succ = TERM_A;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        cmd.accept = 1'b0;
        cmd.op     = OP_NONE;
        cmd.term   = term_reg;
        cmd.emit   = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.phase_lt_one ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                cmd.op     = OP_LOAD;
                term_next  = TERM_A;
                state_next = ST_MLO;
            end
            ST_MLO: begin
                cmd.op     = OP_MLO;
                state_next = ST_MHI;
            end
            ST_MHI: begin
                cmd.op     = OP_MHI;
                state_next = ST_MACC;
            end
            ST_MACC: begin
                cmd.op     = OP_MACC;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.op = OP_UPD;
                if (term_reg == TERM_C) begin
                    state_next = ST_BYTE;
                end else begin
                    term_next  = term_succ;
                    state_next = ST_MLO;
                end
            end
            ST_BYTE: begin
                cmd.op     = OP_BYTE;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.more ? ST_LOAD : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_A;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cubic_resampler_byte_packetizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Each input request yields n = 0..4 results; a new request is taken only once every
// result of the last one has been issued. Each result is computed by three two-part
// multiplies on the 25x18 multiplier of each channel lane.
// Output register lets a result wait while evaluation continues; stalls only at its handoff.
// Reset: aresetn synchronous, active low; clears history, counters, phase to one and
// rate_step to 120422.

module cubic_resampler_byte_packetizer
    import crbp_pkg::*;
#(
    parameter int FRAMES_PER_PACKET = FPP_DEFAULT,
    parameter int SEQ_MODULUS       = SEQ_MOD_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // sample_ch0, sample_ch1, sample_ch2
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [STEP_W-1:0]      cfg_data,  // rate_step
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // byte_ch0, byte_ch1, byte_ch2,
                                                   // packet_seq, slot_in_packet, zero pad
    output logic                        m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    crbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crbp_datapath #(
        .FRAMES_PER_PACKET (FRAMES_PER_PACKET),
        .SEQ_MODULUS       (SEQ_MODULUS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
